// ----- sv/lsc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and constants of the line segment clipper: coordinate and
// arithmetic widths, register indexes, beat structs and sequencer states.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int COORD_BITS   = 24;
  localparam int SLOPE_FRAC   = 16;
  localparam int DIV_BITS     = COORD_BITS + SLOPE_FRAC + 1;
  localparam int PROD_BITS    = DIV_BITS + COORD_BITS + 1;
  localparam int CNT_BITS     = $clog2(DIV_BITS + 1);
  localparam int MAX_PASSES   = 4;
  localparam int PASS_BITS    = $clog2(MAX_PASSES + 1);
  localparam int CFG_IDX_BITS = 2;

  localparam logic signed [COORD_BITS-1:0] WIN_MIN_RST = '0;
  localparam logic signed [COORD_BITS-1:0] WIN_MAX_RST = COORD_BITS'(8388607);

  // outcode bit positions
  localparam int OC_LEFT   = 0;
  localparam int OC_RIGHT  = 1;
  localparam int OC_BOTTOM = 2;
  localparam int OC_TOP    = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_X_MIN = 2'd0,
    REG_X_MAX = 2'd1,
    REG_Y_MIN = 2'd2,
    REG_Y_MAX = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_min;
    logic signed [COORD_BITS-1:0] x_max;
    logic signed [COORD_BITS-1:0] y_min;
    logic signed [COORD_BITS-1:0] y_max;
  } window_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
  } in_beat_t;

  typedef struct packed {
    logic                         visible;
    logic signed [COORD_BITS-1:0] clipped_first_x;
    logic signed [COORD_BITS-1:0] clipped_first_y;
    logic signed [COORD_BITS-1:0] clipped_second_x;
    logic signed [COORD_BITS-1:0] clipped_second_y;
  } out_beat_t;

  typedef enum logic {
    OP_DIV = 1'b0,
    OP_MUL = 1'b1
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_stat_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_TEST = 3'd1,
    S_DIV  = 3'd2,
    S_MUL  = 3'd3,
    S_UPD  = 3'd4,
    S_DONE = 3'd5
  } state_e;

endpackage
`default_nettype wire

// ----- sv/lsc_outcode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_outcode
// Four-bit region code of one point against the clip window.
// ----------------------------------------------------------------------------
module lsc_outcode (
  input  wire logic signed [lsc_pkg::COORD_BITS-1:0] x_i,
  input  wire logic signed [lsc_pkg::COORD_BITS-1:0] y_i,
  input  wire lsc_pkg::window_t                      win_i,
  output logic             [3:0]                     code_o
);
  import lsc_pkg::*;

  always_comb begin
    code_o            = '0;
    code_o[OC_LEFT]   = x_i < win_i.x_min;
    code_o[OC_RIGHT]  = x_i > win_i.x_max;
    code_o[OC_BOTTOM] = y_i < win_i.y_min;
    code_o[OC_TOP]    = y_i > win_i.y_max;
  end

endmodule
`default_nettype wire

// ----- sv/lsc_arith.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_arith
// Shared bit-serial unit: restoring unsigned divide (one quotient bit per
// cycle) or shift-add unsigned multiply (one multiplier bit per cycle).
// ----------------------------------------------------------------------------
module lsc_arith (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire lsc_pkg::arith_cmd_t             cmd_i,
  input  wire logic [lsc_pkg::DIV_BITS-1:0]    opa_i,   // dividend / multiplicand
  input  wire logic [lsc_pkg::COORD_BITS:0]    opb_i,   // divisor / multiplier
  output lsc_pkg::arith_stat_t                 stat_o,
  output logic      [lsc_pkg::PROD_BITS-1:0]   result_o
);
  import lsc_pkg::*;

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  arith_op_e               op_q, op_d;
  logic [CNT_BITS-1:0]     cnt_q, cnt_d;
  logic [PROD_BITS-1:0]    work_q, work_d;
  logic [COORD_BITS:0]     rem_q, rem_d;
  logic [DIV_BITS-1:0]     opa_q, opa_d;
  logic [COORD_BITS:0]     opb_q, opb_d;

  logic [COORD_BITS+1:0]   shifted;
  logic [COORD_BITS+1:0]   trial;

  assign shifted = {rem_q, work_q[DIV_BITS-1]};
  assign trial   = shifted - {1'b0, opb_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    work_d = work_q;
    rem_d  = rem_q;
    opa_d  = opa_q;
    opb_d  = opb_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      op_d   = cmd_i.op;
      opa_d  = opa_i;
      opb_d  = opb_i;
      rem_d  = '0;
      if (cmd_i.op == OP_DIV) begin
        work_d = PROD_BITS'(opa_i);
        cnt_d  = CNT_BITS'(DIV_BITS);
      end else begin
        work_d = '0;
        cnt_d  = CNT_BITS'(COORD_BITS + 1);
      end
    end else if (busy_q) begin
      if (op_q == OP_DIV) begin
        if (!trial[COORD_BITS+1]) begin
          rem_d  = trial[COORD_BITS:0];
          work_d = {work_q[PROD_BITS-2:0], 1'b1};
        end else begin
          rem_d  = shifted[COORD_BITS:0];
          work_d = {work_q[PROD_BITS-2:0], 1'b0};
        end
      end else begin
        work_d = {work_q[PROD_BITS-2:0], 1'b0}
               + (opb_q[COORD_BITS] ? PROD_BITS'(opa_q) : PROD_BITS'(0));
        opb_d  = {opb_q[COORD_BITS-1:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_DIV;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    opa_q  <= opa_d;
    opb_q  <= opb_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign result_o    = work_q;

endmodule
`default_nettype wire

// ----- sv/line_segment_clipper_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// line_segment_clipper_unit
// Cohen-Sutherland clipping of one segment against a configured window.
// ----------------------------------------------------------------------------
// One segment is in flight at a time; in_stall_o is high from acceptance
// until its result beat is taken. A clip pass runs the shared bit-serial
// unit twice, a slope divide and then a multiply, plus setup and update.
// Up to four passes are made; a trivial accept or reject needs none. The
// window registers may be written only while no segment is in flight.
// ----------------------------------------------------------------------------
module line_segment_clipper_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire lsc_pkg::in_beat_t                   in_beat_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output lsc_pkg::out_beat_t                       out_beat_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [lsc_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  wire logic [lsc_pkg::COORD_BITS-1:0]      cfg_data_i
);
  import lsc_pkg::*;

  localparam int N = COORD_BITS;

  state_e state_q, state_d;

  window_t win_q;

  logic signed [N-1:0] ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  logic [PASS_BITS-1:0] pass_q, pass_d;
  logic                 xedge_q, xedge_d;
  logic signed [N-1:0]  edge_q, edge_d;
  logic signed [N-1:0]  bo_q, bo_d;
  logic [N:0]           dmag_q, dmag_d;
  logic                 dneg_q, dneg_d;
  logic                 sgn_q, sgn_d;
  logic                 dzero_q, dzero_d;
  logic                 neg_q, neg_d;
  out_beat_t            out_q, out_d;

  logic [3:0] code_a, code_b, code;
  logic       swap, clip;

  logic signed [N-1:0] pax, pay, pbx, pby, edge_sel;
  logic signed [N:0]   num, den, diff;
  logic [N:0]          num_mag, den_mag, diff_mag;

  arith_cmd_t           cmd;
  arith_stat_t          stat;
  logic [DIV_BITS-1:0]  opa;
  logic [N:0]           opb;
  logic [PROD_BITS-1:0] result;
  logic [DIV_BITS-1:0]  slope;

  logic [N+1:0] mag, bo_ext, moved;

  lsc_outcode u_code_a (.x_i(ax_q), .y_i(ay_q), .win_i(win_q), .code_o(code_a));
  lsc_outcode u_code_b (.x_i(bx_q), .y_i(by_q), .win_i(win_q), .code_o(code_b));

  lsc_arith u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .opa_i    (opa),
    .opb_i    (opb),
    .stat_o   (stat),
    .result_o (result)
  );

  // window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q.x_min <= WIN_MIN_RST;
      win_q.x_max <= WIN_MAX_RST;
      win_q.y_min <= WIN_MIN_RST;
      win_q.y_max <= WIN_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_X_MIN: win_q.x_min <= cfg_data_i;
        REG_X_MAX: win_q.x_max <= cfg_data_i;
        REG_Y_MIN: win_q.y_min <= cfg_data_i;
        REG_Y_MAX: win_q.y_max <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // clip setup: outside end as A, edge choice, slope operands
  always_comb begin
    swap     = (code_a == 4'b0000);
    code     = swap ? code_b : code_a;
    pax      = swap ? bx_q : ax_q;
    pay      = swap ? by_q : ay_q;
    pbx      = swap ? ax_q : bx_q;
    pby      = swap ? ay_q : by_q;
    clip     = (code_a != 4'b0000 || code_b != 4'b0000) && ((code_a & code_b) == 4'b0000)
             && (pass_q < PASS_BITS'(MAX_PASSES));
    if (code[OC_LEFT]) begin
      edge_sel = win_q.x_min;
    end else if (code[OC_RIGHT]) begin
      edge_sel = win_q.x_max;
    end else if (code[OC_BOTTOM]) begin
      edge_sel = win_q.y_min;
    end else begin
      edge_sel = win_q.y_max;
    end
    if (code[OC_LEFT] || code[OC_RIGHT]) begin
      num  = {pby[N-1], pby} - {pay[N-1], pay};
      den  = {pbx[N-1], pbx} - {pax[N-1], pax};
      diff = {pbx[N-1], pbx} - {edge_sel[N-1], edge_sel};
    end else begin
      num  = {pbx[N-1], pbx} - {pax[N-1], pax};
      den  = {pby[N-1], pby} - {pay[N-1], pay};
      diff = {pby[N-1], pby} - {edge_sel[N-1], edge_sel};
    end
    num_mag  = num[N]  ? -num  : num;
    den_mag  = den[N]  ? -den  : den;
    diff_mag = diff[N] ? -diff : diff;
  end

  assign slope  = dzero_q ? '0 : result[DIV_BITS-1:0];
  assign mag    = result[SLOPE_FRAC +: N+2];
  assign bo_ext = {{2{bo_q[N-1]}}, bo_q};
  assign moved  = neg_q ? bo_ext + mag : bo_ext - mag;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_TEST;
      S_TEST: state_d = clip ? S_DIV : S_DONE;
      S_DIV:  if (stat.done) state_d = S_MUL;
      S_MUL:  if (stat.done) state_d = S_UPD;
      S_UPD:  state_d = S_TEST;
      S_DONE: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    out_valid_o = (state_q == S_DONE);
    cmd.start   = 1'b0;
    cmd.op      = OP_DIV;
    opa         = {num_mag, {SLOPE_FRAC{1'b0}}};
    opb         = den_mag;
    case (state_q)
      S_TEST: cmd.start = clip;
      S_DIV: begin
        cmd.start = stat.done;
        cmd.op    = OP_MUL;
        opa       = slope;
        opb       = dmag_q;
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    ax_d    = ax_q;
    ay_d    = ay_q;
    bx_d    = bx_q;
    by_d    = by_q;
    pass_d  = pass_q;
    xedge_d = xedge_q;
    edge_d  = edge_q;
    bo_d    = bo_q;
    dmag_d  = dmag_q;
    dneg_d  = dneg_q;
    sgn_d   = sgn_q;
    dzero_d = dzero_q;
    neg_d   = neg_q;
    out_d   = out_q;
    case (state_q)
      S_IDLE: begin
        ax_d   = in_beat_i.first_x;
        ay_d   = in_beat_i.first_y;
        bx_d   = in_beat_i.second_x;
        by_d   = in_beat_i.second_y;
        pass_d = '0;
      end
      S_TEST: begin
        if (clip) begin
          ax_d    = pax;
          ay_d    = pay;
          bx_d    = pbx;
          by_d    = pby;
          xedge_d = code[OC_LEFT] || code[OC_RIGHT];
          edge_d  = edge_sel;
          bo_d    = (code[OC_LEFT] || code[OC_RIGHT]) ? pby : pbx;
          dmag_d  = diff_mag;
          dneg_d  = diff[N];
          sgn_d   = num[N] ^ den[N];
          dzero_d = (den == '0);
        end else if (code_a == 4'b0000 && code_b == 4'b0000) begin
          out_d.visible          = 1'b1;
          out_d.clipped_first_x  = ax_q;
          out_d.clipped_first_y  = ay_q;
          out_d.clipped_second_x = bx_q;
          out_d.clipped_second_y = by_q;
        end else begin
          out_d = '0;
        end
      end
      S_DIV: if (stat.done) neg_d = sgn_q ^ dneg_q;
      S_UPD: begin
        if (xedge_q) begin
          ax_d = edge_q;
          ay_d = moved[N-1:0];
        end else begin
          ax_d = moved[N-1:0];
          ay_d = edge_q;
        end
        pass_d = pass_q + PASS_BITS'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    bx_q    <= bx_d;
    by_q    <= by_d;
    xedge_q <= xedge_d;
    edge_q  <= edge_d;
    bo_q    <= bo_d;
    dmag_q  <= dmag_d;
    dneg_q  <= dneg_d;
    sgn_q   <= sgn_d;
    dzero_q <= dzero_d;
    neg_q   <= neg_d;
    out_q   <= out_d;
  end

  assign out_beat_o = out_q;

endmodule
`default_nettype wire
